@@ rtl/rtcdte_pkg.sv @@
package rtcdte_pkg;

    // one input item: raw clock register bytes
    typedef struct packed {
        logic [7:0] sec_byte;
        logic [7:0] min_byte;
        logic [7:0] hour_byte;
        logic [7:0] day_byte;
        logic [7:0] month_byte;
        logic [7:0] year_byte;
    } in_t;

    // one result item
    typedef struct packed {
        logic [33:0] epoch_seconds;
        logic [63:0] epoch_nanoseconds;
    } out_t;

    // after decode
    typedef struct packed {
        logic [7:0] sec;
        logic [7:0] min;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] mp;
        logic [7:0] ty;
        logic       y1999;
    } dec_t;

    // register map
    localparam logic REG_BINARY_MODE = 1'b0;

    localparam logic [16:0] DAYS_1999    = 17'd10651;
    localparam logic [16:0] DAYS_2000    = 17'd11017;
    localparam logic [31:0] DIV5_RECIP   = 32'd52429;
    localparam int          DIV5_SHIFT   = 18;
    localparam logic [33:0] SEC_PER_DAY  = 34'd86400;
    localparam logic [19:0] SEC_PER_HOUR = 20'd3600;
    localparam logic [19:0] SEC_PER_MIN  = 20'd60;
    localparam logic [31:0] NS_PER_SEC   = 32'd1000000000;
    localparam logic [8:0]  EPOCH_MIN_NS_ZERO = 9'd0;
    localparam logic [33:0] EPOCH_SEC_MIN = 34'd943920000;

    // bcd byte to value (0 to 165), or the byte unchanged in binary mode; no digit check
    function automatic logic [7:0] bcd_decode(input logic [7:0] b, input logic bin);
        logic [7:0] hi;
        hi = {4'b0, b[7:4]};
        if (bin) begin
            return b;
        end
        return {4'b0, b[3:0]} + (hi << 3) + (hi << 1);
    endfunction

endpackage

@@ rtl/rtc_datetime_to_epoch_top.sv @@
// Converts one set of raw RTC register bytes (second, minute, hour, day, month,
// two-digit year from 2000) to seconds since 1970-01-01 00:00:00 and to that
// value times 1e9 as a wrapping 64-bit nanosecond count. Bytes are BCD-decoded
// unless binary_mode (APB register at address 0, bit 0) is set; digits and
// calendar ranges are not checked. The datapath is a seven-stage pipeline with
// one shared stall: it takes a new item every cycle while no finished item
// waits in the output register with m_ready low.
// The stage count is set by the two chained constant multiplies (divide by five
// and days to seconds) and the split 34 by 30 bit nanosecond product.
module rtc_datetime_to_epoch_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rtcdte_pkg::in_t    s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rtcdte_pkg::out_t   m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import rtcdte_pkg::*;

    logic        binary_mode_reg;
    logic        binary_mode_next;
    logic        en;
    logic        dec_valid;
    dec_t        dec_data;
    logic        secs_valid;
    logic [33:0] secs;

    assign pready = 1'b1;

    always_comb begin
        binary_mode_next = binary_mode_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_BINARY_MODE)) begin
            binary_mode_next = pwdata[0];
        end
        prdata = (paddr[2] == REG_BINARY_MODE) ? {31'b0, binary_mode_reg} : 32'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            binary_mode_reg <= 1'b0;
        end else begin
            binary_mode_reg <= binary_mode_next;
        end
    end

    // whole pipeline advances unless a finished item is waiting
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    rtcdte_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .binary_mode (binary_mode_reg),
        .in_valid    (s_valid),
        .in_data     (s_data),
        .out_valid   (dec_valid),
        .out_data    (dec_data)
    );

    rtcdte_seconds u_seconds (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dec_valid),
        .in_data   (dec_data),
        .out_valid (secs_valid),
        .out_secs  (secs)
    );

    rtcdte_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (secs_valid),
        .in_secs   (secs),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    // 1e9 carries a factor of 2^9, so the low nanosecond bits are always zero
    a_ns_low_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.epoch_nanoseconds[8:0] == EPOCH_MIN_NS_ZERO))
        else $error("nanosecond low bits not zero");

    // earliest reachable date is 1999-11-30 (year 0, month 0, day 0)
    a_secs_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.epoch_seconds >= EPOCH_SEC_MIN))
        else $error("epoch seconds below reachable minimum");

    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input refused with empty output");

    // two register stages sit between the seconds output and m_valid
    a_out_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(secs_valid, 2))
        else $error("result item without a source item");

endmodule

@@ rtl/rtcdte_decode.sv @@
module rtcdte_decode (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               binary_mode,
    input  logic               in_valid,
    input  rtcdte_pkg::in_t    in_data,
    output logic               out_valid,
    output rtcdte_pkg::dec_t   out_data
);
    import rtcdte_pkg::*;

    logic       valid_reg;
    dec_t       data_reg;
    dec_t       data_next;
    logic [7:0] month;
    logic [7:0] year;
    logic       prev_year;

    always_comb begin
        month     = bcd_decode(in_data.month_byte, binary_mode);
        year      = bcd_decode(in_data.year_byte, binary_mode);
        // january and february belong to the previous march-based year
        prev_year = (month <= 8'd2);
        data_next.sec   = bcd_decode(in_data.sec_byte, binary_mode);
        data_next.min   = bcd_decode(in_data.min_byte, binary_mode);
        data_next.hour  = bcd_decode(in_data.hour_byte, binary_mode);
        data_next.day   = bcd_decode(in_data.day_byte, binary_mode);
        data_next.mp    = prev_year ? month + 8'd9 : month - 8'd3;
        data_next.ty    = year - {7'b0, prev_year};
        data_next.y1999 = prev_year && (year == 8'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/rtcdte_seconds.sv @@
module rtcdte_seconds (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  rtcdte_pkg::dec_t   in_data,
    output logic               out_valid,
    output logic [33:0]        out_secs
);
    import rtcdte_pkg::*;

    // stage a: time of day, month term product, year base
    logic        va_reg;
    logic [19:0] hms_a_reg, hms_a_next;
    logic [15:0] prod_reg, prod_next;
    logic [16:0] ybase_reg, ybase_next;
    logic [7:0]  day_reg;
    logic [1:0]  cent;

    // stage b: divide by five, partial day count
    logic        vb_reg;
    logic [19:0] hms_b_reg;
    logic [12:0] q_reg, q_next;
    logic [16:0] dpre_reg, dpre_next;
    logic [31:0] recip_prod;

    // stage c: day count
    logic        vc_reg;
    logic [19:0] hms_c_reg;
    logic [16:0] days_reg, days_next;

    // stage d: seconds
    logic        vd_reg;
    logic [33:0] secs_reg, secs_next;

    always_comb begin
        if (in_data.ty >= 8'd200) begin
            cent = 2'd2;
        end else if (in_data.ty >= 8'd100) begin
            cent = 2'd1;
        end else begin
            cent = 2'd0;
        end
        hms_a_next = {12'b0, in_data.sec} + {12'b0, in_data.min} * SEC_PER_MIN
                   + {12'b0, in_data.hour} * SEC_PER_HOUR;
        prod_next  = {8'b0, in_data.mp} * 16'd153 + 16'd2;
        // year 1999 sits in the previous 400-year era
        ybase_next = in_data.y1999 ? DAYS_1999
                   : DAYS_2000 + {9'b0, in_data.ty} * 17'd365
                     + {11'b0, in_data.ty[7:2]} - {15'b0, cent};

        recip_prod = {16'b0, prod_reg} * DIV5_RECIP;
        q_next     = recip_prod[DIV5_SHIFT +: 13];
        dpre_next  = ybase_reg + {9'b0, day_reg} - 17'd1;

        days_next  = dpre_reg + {4'b0, q_reg};

        secs_next  = {17'b0, days_reg} * SEC_PER_DAY + {14'b0, hms_c_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hms_a_reg <= hms_a_next;
            prod_reg  <= prod_next;
            ybase_reg <= ybase_next;
            day_reg   <= in_data.day;
            hms_b_reg <= hms_a_reg;
            q_reg     <= q_next;
            dpre_reg  <= dpre_next;
            hms_c_reg <= hms_b_reg;
            days_reg  <= days_next;
            secs_reg  <= secs_next;
        end
    end

    assign out_valid = vd_reg;
    assign out_secs  = secs_reg;

endmodule

@@ rtl/rtcdte_scale.sv @@
module rtcdte_scale (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [33:0]        in_secs,
    output logic               out_valid,
    output rtcdte_pkg::out_t   out_data
);
    import rtcdte_pkg::*;

    logic        ve_reg;
    logic [33:0] secs_e_reg;
    logic [63:0] lo_reg, lo_next;
    logic [31:0] hi_reg, hi_next;

    logic        vf_reg;
    out_t        out_reg, out_next;

    always_comb begin
        // split the 34-bit count: low word product plus top two bits shifted up
        lo_next = {32'b0, in_secs[31:0]} * {32'b0, NS_PER_SEC};
        hi_next = {30'b0, in_secs[33:32]} * NS_PER_SEC;
        out_next.epoch_seconds     = secs_e_reg;
        out_next.epoch_nanoseconds = lo_reg + {hi_reg, 32'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end else if (en) begin
            ve_reg <= in_valid;
            vf_reg <= ve_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            secs_e_reg <= in_secs;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            out_reg    <= out_next;
        end
    end

    assign out_valid = vf_reg;
    assign out_data  = out_reg;

endmodule
